>>> sv/dctm_pkg.sv
// Shared types and constants of the delayed channel tag merger.
`timescale 1ns / 1ps

package dctm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TIME_W  = 64;
  localparam int CH_W    = 16;
  localparam int DLY_W   = 40;
  localparam int TYPE_W  = 3;
  localparam int MISS_W  = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DLY_W;

  localparam int IN_USED_W  = TYPE_W + CH_W + TIME_W + MISS_W;
  localparam int OUT_USED_W = TYPE_W + CH_W + TIME_W + MISS_W + 1;
  localparam int TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_CH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd2;

  localparam logic [TYPE_W-1:0] TAG_TIME     = 3'd0;
  localparam logic [TYPE_W-1:0] TAG_ERROR    = 3'd1;
  localparam logic [TYPE_W-1:0] TAG_OVF_BEG  = 3'd2;
  localparam logic [TYPE_W-1:0] TAG_OVF_END  = 3'd3;
  localparam logic [TYPE_W-1:0] TAG_MISSED   = 3'd4;

  localparam logic CMD_TAG   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CHK,
    ST_ADD,
    ST_TAG
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic {
    OUT_COPY,
    OUT_TAG
  } out_src_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/dctm_queue.sv
// Circular queue of delayed copy times with registered read port.
`timescale 1ns / 1ps

module dctm_queue
  import dctm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_cmd_t            cmd_i,
  input  logic [TIME_W-1:0] wdata_i,
  output logic [TIME_W-1:0] rdata_o,
  output q_stat_t           stat_o
);

  logic [TIME_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] rdata_q;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (cmd_i.clear) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      cnt_d    = '0;
    end else begin
      if (cmd_i.pop) begin
        rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (cmd_i.push) begin
        wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      unique case ({cmd_i.push, cmd_i.pop})
        2'b10:   cnt_d = cnt_q + 1'b1;
        2'b01:   cnt_d = cnt_q - 1'b1;
        default: cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // read follows the next head pointer so data is ready after a pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    rdata_q <= mem[rd_ptr_d];
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push into full queue");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> stat_o.empty)
    else $error("queue not empty after clear");

endmodule

>>> sv/dctm_alu.sv
// Shared 64-bit add/subtract unit with registered result.
`timescale 1ns / 1ps

module dctm_alu
  import dctm_pkg::*;
(
  input  logic              clk_i,
  input  alu_op_e           op_i,
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output logic [TIME_W-1:0] res_o
);

  logic [TIME_W-1:0] b_inv;
  logic              sub;
  logic [TIME_W-1:0] res_q;

  assign sub   = (op_i == ALU_SUB);
  assign b_inv = b_i ^ {TIME_W{sub}};

  always_ff @(posedge clk_i) begin
    res_q <= a_i + b_inv + TIME_W'(sub);
  end

  assign res_o = res_q;

endmodule

>>> sv/delayed_channel_tag_merger_unit.sv
// Top level of the delayed channel tag merger: sequencer, registers, output stage.
`timescale 1ns / 1ps

// Usage:
//  s_axis carries tags and flush commands (tuser = cmd), m_axis carries the
//  merged tag stream; tlast marks the final result caused by one input item.
//  The cfg port writes source channel, virtual channel and delay; the user must
//  write it only while idle, the block does not enforce this. The block takes
//  one item at a time: s_axis_tready is high only between items. Each queued
//  copy is checked by one pass through the shared 64-bit add/subtract unit
//  (a compare state, then a check state); then an add state forms the delayed
//  time and a tag state passes the tag on. A flush command ends after the checks.
//  One released copy is held back until it is known whether it is the last.
//  A stalled m_axis stops the sequencer where it next needs the output
//  register; nothing is lost. Reset empties the queue, clears overflow mode
//  and the registers, and leaves the output empty; no clearing pass is needed.
module delayed_channel_tag_merger_unit
  import dctm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tag_type, channel, time_req, missed_count
  input  logic [TDATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_type, out_channel, out_time, out_missed, copy_dropped
  output logic [TDATA_W-1:0]   m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int PAD_W = TDATA_W - OUT_USED_W;

  state_e            state_q, state_d;
  logic [CH_W-1:0]   src_ch_q, virt_ch_q;
  logic [DLY_W-1:0]  delay_q;

  logic              cmd_q;
  logic [TYPE_W-1:0] type_q;
  logic [CH_W-1:0]   chan_q;
  logic [TIME_W-1:0] time_q;
  logic [MISS_W-1:0] miss_q;

  logic [TIME_W-1:0] hold_t_q;
  logic              hold_v_q;
  logic              ovf_q;

  logic [TDATA_W-1:0] out_data_q;
  logic               out_last_q;
  logic               out_v_q;

  q_cmd_t            q_cmd;
  q_stat_t           q_stat;
  logic [TIME_W-1:0] q_rdata;

  alu_op_e           alu_op;
  logic [TIME_W-1:0] alu_a, alu_b, alu_res;

  logic     out_free, go, older, copy_req;
  logic     in_load, hold_load, hold_clr, out_load, out_last;
  out_src_e out_src;

  dctm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (q_cmd),
    .wdata_i (alu_res),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  dctm_alu u_alu (
    .clk_i (clk_i),
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign out_free = !out_v_q || m_axis_tready;
  assign go       = !hold_v_q || out_free;
  assign older    = !q_stat.empty && alu_res[TIME_W-1];
  assign copy_req = (type_q == TAG_TIME) && (chan_q == src_ch_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_CMP;
      end
      ST_CMP: state_d = ST_CHK;
      ST_CHK: begin
        if (go) begin
          if (older) state_d = ST_CMP;
          else if (cmd_q == CMD_FLUSH) state_d = ST_IDLE;
          else state_d = ST_ADD;
        end
      end
      ST_ADD: state_d = ST_TAG;
      ST_TAG: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    in_load       = 1'b0;
    hold_load     = 1'b0;
    hold_clr      = 1'b0;
    out_load      = 1'b0;
    out_last      = 1'b0;
    out_src       = OUT_COPY;
    q_cmd         = '0;
    alu_op        = ALU_SUB;
    alu_a         = q_rdata;
    alu_b         = time_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        in_load       = s_axis_tvalid;
      end
      ST_CMP: begin
        alu_op = ALU_SUB;
      end
      ST_CHK: begin
        if (go) begin
          out_load = hold_v_q;
          if (older) begin
            q_cmd.pop = 1'b1;
            hold_load = 1'b1;
          end else begin
            hold_clr = 1'b1;
            out_last = (cmd_q == CMD_FLUSH);
          end
        end
      end
      ST_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = time_q;
        alu_b  = TIME_W'(delay_q);
      end
      ST_TAG: begin
        // keep the delayed time in the unit while the output stalls
        alu_op = ALU_ADD;
        alu_a  = time_q;
        alu_b  = TIME_W'(delay_q);
        if (out_free) begin
          out_load    = 1'b1;
          out_last    = 1'b1;
          out_src     = OUT_TAG;
          q_cmd.push  = copy_req && !q_stat.full;
          q_cmd.clear = (type_q == TAG_ERROR);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      src_ch_q  <= '0;
      virt_ch_q <= '0;
      delay_q   <= '0;
      hold_v_q  <= 1'b0;
      ovf_q     <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SRC_CH:  src_ch_q  <= cfg_wdata_i[CH_W-1:0];
          CFG_VIRT_CH: virt_ch_q <= cfg_wdata_i[CH_W-1:0];
          CFG_DELAY:   delay_q   <= cfg_wdata_i[DLY_W-1:0];
          default: ;
        endcase
      end
      if (hold_load) hold_v_q <= 1'b1;
      else if (hold_clr) hold_v_q <= 1'b0;
      if (out_load && out_src == OUT_TAG) begin
        if (type_q == TAG_OVF_BEG) ovf_q <= 1'b1;
        else if (type_q == TAG_OVF_END) ovf_q <= 1'b0;
      end
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q  <= s_axis_tuser;
      type_q <= s_axis_tdata[TYPE_W-1:0];
      chan_q <= s_axis_tdata[TYPE_W +: CH_W];
      time_q <= s_axis_tdata[TYPE_W + CH_W +: TIME_W];
      miss_q <= s_axis_tdata[TYPE_W + CH_W + TIME_W +: MISS_W];
    end
    if (hold_load) hold_t_q <= alu_a;
    if (out_load) begin
      out_last_q <= out_last;
      if (out_src == OUT_TAG) begin
        out_data_q <= {{PAD_W{1'b0}}, copy_req && q_stat.full, miss_q, time_q, chan_q, type_q};
      end else begin
        out_data_q <= {{PAD_W{1'b0}}, 1'b0, (ovf_q ? MISS_W'(1) : MISS_W'(0)),
                       hold_t_q, virt_ch_q, (ovf_q ? TAG_MISSED : TAG_TIME)};
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_CMP))
    else $error("accepted item did not start a check");

  a_hold_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAG) |-> !hold_v_q)
    else $error("held copy still pending at tag pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

>>> test/tb.sv
// Self-checking testbench for the delayed channel tag merger: directed and random tag streams.
`timescale 1ns / 1ps

module tb;
  import dctm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [CH_W-1:0]   chan;
    logic [TIME_W-1:0] stamp;
    logic [MISS_W-1:0] miss;
    logic              dropped;
    logic              last;
  } tag_result_t;

  class merge_scoreboard;
    logic [CH_W-1:0]   src_ch;
    logic [CH_W-1:0]   virt_ch;
    logic [DLY_W-1:0]  delay;
    logic [TIME_W-1:0] copy_times [QUEUE_DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       n_copies;
    bit                ovf;
    tag_result_t       expected_tags [int unsigned];
    int unsigned       exp_wr;
    int unsigned       exp_rd;
    int unsigned       errors;

    function new();
      src_ch   = '0;
      virt_ch  = '0;
      delay    = '0;
      rd_ptr   = 0;
      wr_ptr   = 0;
      n_copies = 0;
      ovf      = 1'b0;
      exp_wr   = 0;
      exp_rd   = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SRC_CH:  src_ch  = val[CH_W-1:0];
        CFG_VIRT_CH: virt_ch = val[CH_W-1:0];
        CFG_DELAY:   delay   = val[DLY_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return exp_wr - exp_rd;
    endfunction

    function void push_result(logic [TYPE_W-1:0] typ, logic [CH_W-1:0] chan,
                              logic [TIME_W-1:0] stamp, logic [MISS_W-1:0] miss,
                              logic dropped);
      tag_result_t r;
      r.typ     = typ;
      r.chan    = chan;
      r.stamp   = stamp;
      r.miss    = miss;
      r.dropped = dropped;
      r.last    = 1'b0;
      expected_tags[exp_wr] = r;
      exp_wr++;
    endfunction

    // Emit every queued copy strictly earlier than the bound (wrapping difference).
    function void release_before(logic [TIME_W-1:0] bound);
      logic [TIME_W-1:0] diff;
      while (n_copies > 0) begin
        diff = copy_times[rd_ptr] - bound;
        if (!diff[TIME_W-1]) break;
        if (ovf) push_result(TAG_MISSED, virt_ch, copy_times[rd_ptr], MISS_W'(1), 1'b0);
        else push_result(TAG_TIME, virt_ch, copy_times[rd_ptr], '0, 1'b0);
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        n_copies--;
      end
    endfunction

    function void note_item(logic cmd, logic [TYPE_W-1:0] typ, logic [CH_W-1:0] chan,
                            logic [TIME_W-1:0] stamp, logic [MISS_W-1:0] miss);
      int unsigned first;
      logic        dropped;
      first   = exp_wr;
      dropped = 1'b0;
      release_before(stamp);
      if (cmd == CMD_TAG) begin
        if (typ == TAG_TIME && chan == src_ch) begin
          if (n_copies < QUEUE_DEPTH) begin
            copy_times[wr_ptr] = stamp + TIME_W'(delay);
            wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
            n_copies++;
          end else begin
            dropped = 1'b1;
          end
        end else if (typ == TAG_ERROR) begin
          rd_ptr   = 0;
          wr_ptr   = 0;
          n_copies = 0;
        end else if (typ == TAG_OVF_BEG) begin
          ovf = 1'b1;
        end else if (typ == TAG_OVF_END) begin
          ovf = 1'b0;
        end
        push_result(typ, chan, stamp, miss, dropped);
      end
      if (exp_wr > first) expected_tags[exp_wr - 1].last = 1'b1;
    endfunction

    function void compare(string what, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [TDATA_W-1:0] word, logic tl);
      tag_result_t want;
      tag_result_t got;
      got.typ     = word[TYPE_W-1:0];
      got.chan    = word[TYPE_W +: CH_W];
      got.stamp   = word[TYPE_W+CH_W +: TIME_W];
      got.miss    = word[TYPE_W+CH_W+TIME_W +: MISS_W];
      got.dropped = word[OUT_USED_W-1];
      got.last    = tl;
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t: unexpected item, expected none, got %h last %b", $time, word, tl);
      end else begin
        want = expected_tags[exp_rd];
        expected_tags.delete(exp_rd);
        exp_rd++;
        compare("out_type", 64'(want.typ), 64'(got.typ));
        compare("out_channel", 64'(want.chan), 64'(got.chan));
        compare("out_time", want.stamp, got.stamp);
        compare("out_missed", 64'(want.miss), 64'(got.miss));
        compare("copy_dropped", 64'(want.dropped), 64'(got.dropped));
        compare("last", 64'(want.last), 64'(got.last));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;

  merge_scoreboard sb;
  int              tx_idle = 8;
  int              rx_idle = 45;
  int              quiet_cycles = 0;

  delayed_channel_tag_merger_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("delayed_channel_tag_merger_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic cmd, input logic [TYPE_W-1:0] typ,
                           input logic [CH_W-1:0] chan, input logic [TIME_W-1:0] stamp,
                           input logic [MISS_W-1:0] miss);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= TDATA_W'({miss, stamp, chan, typ});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(cmd, typ, chan, stamp, miss);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Unused index first: it must be ignored.
  task automatic next_phase(input logic [CH_W-1:0] src, input logic [CH_W-1:0] virt,
                            input logic [DLY_W-1:0] dly);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= CFG_W'({$urandom, $urandom});
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SRC_CH;
    cfg_wdata_i <= CFG_W'(src);
    @(posedge clk_i);
    sb.set_reg(CFG_SRC_CH, CFG_W'(src));
    cfg_idx_i   <= CFG_VIRT_CH;
    cfg_wdata_i <= CFG_W'(virt);
    @(posedge clk_i);
    sb.set_reg(CFG_VIRT_CH, CFG_W'(virt));
    cfg_idx_i   <= CFG_DELAY;
    cfg_wdata_i <= CFG_W'(dly);
    @(posedge clk_i);
    sb.set_reg(CFG_DELAY, CFG_W'(dly));
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(CMD_TAG, TAG_TIME, 16'd5, 64'd0, 16'd0);
    send_item(CMD_TAG, TAG_TIME, 16'd5, 64'd1000, 16'hFFFF);
    send_item(CMD_TAG, TAG_MISSED, 16'hFFFF, 64'd1500, 16'hFFFF);
    send_item(CMD_TAG, TAG_OVF_BEG, 16'd9, 64'd1600, 16'd3);
    send_item(CMD_FLUSH, TAG_ERROR, 16'd5, 64'd3000, 16'd7);
    send_item(CMD_TAG, TAG_OVF_END, 16'd0, 64'd3100, 16'd0);
    // fill the queue, the last copy is lost
    for (int k = 0; k <= QUEUE_DEPTH; k++)
      send_item(CMD_TAG, TAG_TIME, 16'd5, 64'd3200 + 64'(k), MISS_W'($urandom));
    send_item(CMD_TAG, TAG_ERROR, 16'h1234, 64'h7FFF_FFFF_FFFF_FFFF, 16'd0);
    send_item(CMD_TAG, TAG_TIME, 16'd5, -64'sd5, 16'd1);
    send_item(CMD_FLUSH, TAG_TIME, 16'd0, 64'd0, 16'd0);
    send_item(CMD_FLUSH, 3'd7, 16'hFFFF, 64'h8000_0000_0000_0000, 16'hFFFF);
  endtask

  task automatic run_random(input int n_items, input logic [TIME_W-1:0] start);
    logic [TIME_W-1:0] now_ps;
    logic [TIME_W-1:0] unit_ps;
    logic [TIME_W-1:0] step;
    int                pick;
    now_ps  = start;
    unit_ps = TIME_W'(sb.delay / 100) + 64'd1;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2 || $urandom_range(0, 99) < 3) pause_until_drained();
      if ($urandom_range(0, 3) == 0) step = unit_ps * $urandom_range(0, 400);
      else step = unit_ps * $urandom_range(0, 20);
      pick = $urandom_range(0, 99);
      if (pick < 94) now_ps = now_ps + step;
      if (pick < 55)
        send_item(CMD_TAG, TAG_TIME, sb.src_ch, now_ps, MISS_W'($urandom));
      else if (pick < 65)
        send_item(CMD_TAG, TAG_TIME, CH_W'($urandom), now_ps, MISS_W'($urandom));
      else if (pick < 70)
        send_item(CMD_TAG, TAG_ERROR, CH_W'($urandom), now_ps, MISS_W'($urandom));
      else if (pick < 76)
        send_item(CMD_TAG, TAG_OVF_BEG, CH_W'($urandom), now_ps, MISS_W'($urandom));
      else if (pick < 82)
        send_item(CMD_TAG, TAG_OVF_END, CH_W'($urandom), now_ps, MISS_W'($urandom));
      else if (pick < 88)
        send_item(CMD_TAG, TAG_MISSED, CH_W'($urandom), now_ps, MISS_W'($urandom));
      else if (pick < 94)
        send_item(CMD_FLUSH, TYPE_W'($urandom), CH_W'($urandom), now_ps, MISS_W'($urandom));
      else
        send_item(1'($urandom), TYPE_W'($urandom), CH_W'($urandom), {$urandom, $urandom},
                  MISS_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    next_phase(16'd5, 16'hFFFF, 40'd1000);
    run_directed();
    next_phase(16'd0, 16'd0, '0);
    run_random(34, {$urandom, $urandom});
    tx_idle = 45;
    rx_idle = 8;
    next_phase(16'hFFFF, 16'd1234, '1);
    run_random(35, 64'h7FFF_FFFF_0000_0000);
    tx_idle = 0;
    rx_idle = 0;
    next_phase(CH_W'($urandom), CH_W'($urandom), DLY_W'({$urandom, $urandom}));
    run_random(34, {$urandom, $urandom});
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t: %0d expected items never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("delayed_channel_tag_merger_unit verification clean");
    end else begin
      $display("delayed_channel_tag_merger_unit verification failed");
    end
    $finish;
  end

endmodule
